[rtl/wtsp_pkg.sv]
// wtsp_pkg: shared types and constants for the world to screen projection block
// no dependencies
`default_nettype none
package wtsp_pkg;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PROJECT = 1'b1;
   localparam logic [0:0] CSR_WIDTH = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic op;
      logic [3:0] coef_index;
      logic signed [31:0] coef_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC, ST_DIV, ST_SCALE, ST_OUT
   } state_type;
endpackage
`default_nettype wire

[rtl/wtsp_queue.sv]
// wtsp_queue: small word queue between front and back end
// depends on wtsp_pkg
`default_nettype none
module wtsp_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wtsp_pkg::item_type push_item,
   output logic full,
   input  wire logic pop,
   output wtsp_pkg::item_type pop_item,
   output logic empty
);
   import wtsp_pkg::*;
   item_type mem_ff [QUEUE_DEPTH];
   logic [$clog2(QUEUE_DEPTH)-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [$clog2(QUEUE_DEPTH):0] cnt_ff, cnt_in;

   assign full = cnt_ff == ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wr_in = wr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_in = rd_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ff] <= push_item;
      end
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

[rtl/wtsp_front.sv]
// wtsp_front: accepts words, writes matrix coefficients, queues projections
// depends on wtsp_pkg
`default_nettype none
module wtsp_front (
   input  wire logic clock,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wtsp_pkg::item_type req_item,
   output logic push,
   input  wire logic full,
   input  wire logic empty,
   input  wire logic busy,
   input  wire logic [3:0] rd_addr,
   output logic signed [31:0] rd_data
);
   import wtsp_pkg::*;
   logic signed [31:0] mat_ff [16];
   // a load waits until no projection is queued or running
   assign req_tready = !full && (req_item.op == OP_PROJECT || (empty && !busy));
   assign push = req_tvalid && req_tready && req_item.op == OP_PROJECT;
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready && req_item.op == OP_LOAD) begin
         mat_ff[req_item.coef_index] <= req_item.coef_value;
      end
      rd_data <= mat_ff[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/wtsp_back.sv]
// wtsp_back: shared multiply-accumulate, serial divider and viewport scaling
// depends on wtsp_pkg
`default_nettype none
module wtsp_back #(
   parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic empty,
   input  wtsp_pkg::item_type item,
   output logic pop,
   output logic busy,
   output logic [3:0] rd_addr,
   input  wire logic signed [31:0] rd_data,
   input  wire logic [15:0] width,
   input  wire logic [15:0] height,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [64:0] rsp_word
);
   import wtsp_pkg::*;
   localparam int AW = 72;
   localparam logic signed [AW-1:0] THRESH = AW'(((64'sd1 <<< FRAC_BITS) + 5) / 10);
   localparam int QW = 33;
   localparam logic [6:0] DIV_DONE = 7'h7f;

   state_type st_ff, st_in;
   logic [4:0] step_ff;
   logic [1:0] row_ff;
   logic signed [AW-1:0] acc_ff, cx_ff, cy_ff, cw_ff;
   logic signed [63:0] prod_ff;
   logic pv_ff;
   logic [AW-1:0] rem_ff, num_ff;
   logic [QW-1:0] q_ff;
   logic [6:0] dcnt_ff;
   logic dsel_ff, neg_ff;
   logic signed [33:0] nx_ff, ny_ff;
   logic signed [51:0] sc_ff;
   logic [1:0] sstep_ff;
   logic signed [31:0] sx_ff, sy_ff;
   logic vis_ff, outv_ff;

   function automatic logic signed [31:0] sat(input logic signed [55:0] v);
      if (v > 56'sh7fffffff) return 32'sh7fffffff;
      if (v < -56'sh80000000) return -32'sh80000000;
      return v[31:0];
   endfunction

   logic signed [31:0] pt;
   logic [1:0] rsel;
   always_comb begin
      rsel = (row_ff == 2'd2) ? 2'd3 : row_ff;
      if (step_ff >= 5'd3) rd_addr = {2'd3, rsel};
      else rd_addr = {step_ff[1:0], rsel};
      case (step_ff[1:0])
         2'd1: pt = item.point_x;
         2'd2: pt = item.point_y;
         default: pt = item.point_z;
      endcase
   end

   // next state
   logic mac_done, div_done;
   assign mac_done = row_ff == 2'd2 && step_ff == 5'd5;
   assign div_done = dsel_ff && dcnt_ff == DIV_DONE;
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (!empty) st_in = ST_MAC;
         ST_MAC: if (mac_done) st_in = ST_DIV;
         ST_DIV: begin
            if (cw_ff < THRESH) st_in = ST_OUT;
            else if (div_done) st_in = ST_SCALE;
         end
         ST_SCALE: if (sstep_ff == 2'd3) st_in = ST_OUT;
         ST_OUT: if (!outv_ff) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop = st_ff == ST_OUT && !outv_ff;
      busy = st_ff != ST_IDLE;
      rsp_tvalid = outv_ff;
      rsp_word = {sy_ff, sx_ff, vis_ff};
   end

   logic [AW-1:0] dnum, rsh, wmag;
   logic signed [AW-1:0] dsrc;
   logic signed [AW-1:0] fl;
   always_comb begin
      dsrc = dsel_ff ? cy_ff : cx_ff;
      dnum = dsrc[AW-1] ? AW'(-dsrc) : AW'(dsrc);
      wmag = AW'(cw_ff);
      rsh = {rem_ff[AW-2:0], num_ff[AW-1]};
      fl = (acc_ff >>> FRAC_BITS) + AW'(rd_data);
   end

   logic signed [33:0] nres;
   logic [15:0] half;
   always_comb begin
      if (neg_ff) nres = (q_ff > 33'h80000000) ? -34'sh80000000 : -$signed({1'b0, q_ff});
      else nres = (q_ff > 33'h7fffffff) ? 34'sh7fffffff : $signed({1'b0, q_ff});
      half = sstep_ff[1] ? (height >> 1) : (width >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         outv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff != ST_OUT && st_in == ST_OUT) outv_ff <= 1'b1;
         else if (outv_ff && rsp_tready) outv_ff <= 1'b0;
      end
      case (st_ff)
         ST_IDLE: begin
            step_ff <= '0;
            row_ff <= '0;
            pv_ff <= 1'b0;
            acc_ff <= '0;
         end
         ST_MAC: begin
            // step 1..3 issue products, 2..4 accumulate, 5 floors and adds translation
            pv_ff <= step_ff >= 5'd1 && step_ff <= 5'd3;
            prod_ff <= 64'(pt) * 64'(rd_data);
            if (step_ff == 5'd5) begin
               case (row_ff)
                  2'd0: cx_ff <= fl;
                  2'd1: cy_ff <= fl;
                  default: cw_ff <= fl;
               endcase
               acc_ff <= '0;
               step_ff <= '0;
               row_ff <= row_ff + 1'b1;
            end else begin
               if (pv_ff) acc_ff <= acc_ff + AW'(prod_ff);
               step_ff <= step_ff + 1'b1;
            end
            dcnt_ff <= '0;
            dsel_ff <= 1'b0;
         end
         ST_DIV: begin
            if (cw_ff < THRESH) begin
               vis_ff <= 1'b0;
               sx_ff <= '0;
               sy_ff <= '0;
            end else if (dcnt_ff == '0) begin
               num_ff <= dnum << (AW - 1 - 56);
               rem_ff <= '0;
               q_ff <= '0;
               neg_ff <= dsrc[AW-1];
               dcnt_ff <= 7'd1;
               vis_ff <= 1'b1;
            end else if (dcnt_ff <= 7'd57 + 7'(FRAC_BITS)) begin
               num_ff <= num_ff << 1;
               if (rsh >= wmag) begin
                  rem_ff <= rsh - wmag;
                  q_ff <= (q_ff == {QW{1'b1}}) ? q_ff : {q_ff[QW-2:0], 1'b1} |
                          {q_ff[QW-1], {(QW-1){1'b0}}};
               end else begin
                  rem_ff <= rsh;
                  q_ff <= {q_ff[QW-2:0], 1'b0} | {q_ff[QW-1], {(QW-1){1'b0}}};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
            end else if (dcnt_ff != DIV_DONE) begin
               if (!dsel_ff) nx_ff <= nres; else ny_ff <= nres;
               dsel_ff <= 1'b1;
               dcnt_ff <= dsel_ff ? DIV_DONE : '0;
            end
            sstep_ff <= '0;
         end
         ST_SCALE: begin
            case (sstep_ff)
               2'd0: sc_ff <= 52'($signed({1'b0, half})) * 52'(nx_ff);
               2'd1: sx_ff <= sat(56'(sc_ff) + 56'(nx_ff) +
                          (56'($signed({1'b0, width >> 1})) <<< FRAC_BITS));
               2'd2: sc_ff <= 52'($signed({1'b0, half})) * 52'(ny_ff);
               default: sy_ff <= sat(-56'(sc_ff) + 56'(ny_ff) +
                          (56'($signed({1'b0, height >> 1})) <<< FRAC_BITS));
            endcase
            sstep_ff <= sstep_ff + 1'b1;
         end
         default: ;
      endcase
   end
   logic unused;
   assign unused = ^{item.op, item.coef_index, item.coef_value};
endmodule
`default_nettype wire

[rtl/world_to_screen_projection.sv]
// world_to_screen_projection: top level of the projection block
// depends on wtsp_pkg, wtsp_front, wtsp_queue, wtsp_back
// channel  dir  fields (low bit up)
// req      in   tuser op; tdata coef_index, coef_value, point_x, point_y, point_z
// rsp      out  tdata visible, screen_x, screen_y
// csr      in   write enable, index, 16 bit data
// a load word is written once no projection is queued or running
// a project word runs the shared mac for each row, then the serial divider
// (one bit per cycle, two quotients); an invisible point skips the divider and scaling
// words queue two deep in front of the back end; a stalled result holds the back end
// reset is synchronous and clears control state; the matrix is undefined until loaded
`default_nettype none
module world_to_screen_projection #(
   parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [135:0] req_tdata, // coef_index, coef_value, point_x, point_y, point_z
   input  wire logic req_tuser,         // op
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [71:0] rsp_tdata,       // visible, screen_x, screen_y
   input  wire logic csr_we,
   input  wire logic [0:0] csr_index,
   input  wire logic [15:0] csr_wdata
);
   import wtsp_pkg::*;
   item_type in_item, q_item;
   logic push, full, pop, empty, busy;
   logic [3:0] rd_addr;
   logic signed [31:0] rd_data;
   logic [15:0] width_ff, height_ff;
   logic [64:0] word;

   assign in_item = '{op: req_tuser, coef_index: req_tdata[3:0],
      coef_value: req_tdata[35:4], point_x: req_tdata[67:36],
      point_y: req_tdata[99:68], point_z: req_tdata[131:100]};
   assign rsp_tdata = {7'd0, word};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 16'd1024;
         height_ff <= 16'd768;
      end else if (csr_we) begin
         if (csr_index == CSR_WIDTH) width_ff <= csr_wdata;
         else height_ff <= csr_wdata;
      end
   end

   wtsp_front u_front (.clock, .req_tvalid, .req_tready, .req_item(in_item), .push,
      .full, .empty, .busy, .rd_addr, .rd_data);
   wtsp_queue u_queue (.clock, .reset, .push, .push_item(in_item), .full, .pop,
      .pop_item(q_item), .empty);
   wtsp_back #(.FRAC_BITS(FRAC_BITS)) u_back (.clock, .reset, .empty, .item(q_item),
      .pop, .busy, .rd_addr, .rd_data, .width(width_ff), .height(height_ff), .rsp_tvalid,
      .rsp_tready, .rsp_word(word));
   logic unused;
   assign unused = ^req_tdata[135:132];
endmodule
`default_nettype wire

[rtl/wtsp_checker.sv]
// wtsp_checker: port level checks of the projection block
// bound to world_to_screen_projection
`default_nettype none
module wtsp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [71:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp");
   a_invis: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[64:1] == '0) else $error("invisible");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:65] == '0) else $error("pad");
endmodule
bind world_to_screen_projection wtsp_checker u_chk (.clock, .reset, .rsp_tvalid,
   .rsp_tready, .rsp_tdata);
`default_nettype wire
